/* hdl/akf_pkg.sv */
`default_nettype none
package akf_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int WORD_W = 32;
    localparam int REG_W = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [REG_W-1:0] PROCESS_NOISE_RESET = 31'd16384;
    localparam logic [REG_W-1:0] MEAS_NOISE_RESET = 31'd22938;
    localparam logic [REG_W-1:0] ALT_VAR_RESET = 31'd98304;
    localparam logic [REG_W-1:0] SPEED_VAR_RESET = 31'd65536;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALT_VAR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_VAR = 2'd3;

    // Operation codes of the shared arithmetic unit.
    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL
    } alu_op_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALU,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } seq_state_t;

    localparam int STEP_W = 5;

    // Saturate a 66-bit value to the signed 32-bit range.
    function automatic logic [WORD_W:0] sat32(input logic signed [65:0] v);
        logic [WORD_W:0] r;
        if (v > 66'sd2147483647)
            r = {1'b1, 32'h7FFF_FFFF};
        else if (v < -66'sd2147483648)
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, v[WORD_W-1:0]};
        return r;
    endfunction

endpackage
`default_nettype wire

/* hdl/altitude_kalman_filter_unit.sv */
`default_nettype none
// Two-state altitude and vertical speed Kalman filter in signed fixed point.
// Input items arrive on the s_axis channel: measured altitude, averaged
// vertical acceleration and the time step. Each item gives exactly one
// result item on m_axis: the filtered altitude, the vertical speed and a
// flag that is set when any intermediate value was clipped.
// The block works on one item at a time. A single shared add, subtract and
// multiply unit carries out the 27 arithmetic steps of one update under a
// small sequencer, and a radix-2 divider forms each of the two gains at one
// quotient bit per cycle.
// s_axis_tready is high only while the block is idle. The result is held in
// an output register until the receiver takes it; a stalled receiver simply
// holds the block in its output state.
// Reset clears the estimates, loads the covariance diagonal from the reset
// values of the initial variance registers and restores all register
// defaults. Writing register 2 or 3 reloads the covariance, keeping the
// estimates. Configuration must be written only while the block is idle; the block itself does not enforce this.
module altitude_kalman_filter_unit #(
    parameter int FRAC_BITS = akf_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // measured_altitude [31:0], vertical_accel [63:32], step_time [80:64]
    input  wire logic [87:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // filtered_altitude [31:0], vertical_speed [63:32], saturated [64]
    output logic [71:0]      m_axis_tdata,
    input  wire logic        cfg_we,
    input  wire logic [akf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [akf_pkg::REG_W-1:0]     cfg_data
);
    // Scratch slots holding operands and intermediate values.
    typedef enum logic [4:0] {
        V_ALT, V_SPD, V_PAA, V_PAS, V_PSA, V_PSS,
        V_MEAS, V_ACC, V_DT, V_Q, V_R, V_ONE,
        V_PA, V_PS, V_P1AA, V_P1AS, V_P1SA, V_P1SS,
        V_S, V_KA, V_KS, V_INNOV, V_NKA, V_T0, V_T1
    } slot_t;

    typedef struct packed {
        akf_pkg::alu_op_t op;
        slot_t            a;
        slot_t            b;
        slot_t            d;
        logic             div;
        logic             last;
    } micro_t;

    localparam int NSLOT = 25;

    logic signed [31:0] slot_reg [NSLOT];
    logic [akf_pkg::REG_W-1:0] q_reg, r_reg, avar_reg, svar_reg;
    akf_pkg::seq_state_t state_reg, state_next;
    logic [akf_pkg::STEP_W-1:0] step_reg, step_next;
    logic clip_reg;
    logic [71:0] out_reg;
    micro_t mi;
    logic alu_start, div_start;
    logic alu_done, alu_clip, div_done, div_clip;
    logic signed [31:0] alu_res, div_res;

    // Microcode: one operation per step, destination written back on done.
    always_comb
    begin
        mi = '{akf_pkg::OP_ADD, V_ALT, V_ALT, V_T0, 1'b0, 1'b0};
        case (step_reg)
            5'd0:  mi = '{akf_pkg::OP_MUL, V_DT,   V_SPD,  V_T0,   1'b0, 1'b0};
            5'd1:  mi = '{akf_pkg::OP_ADD, V_ALT,  V_T0,   V_PA,   1'b0, 1'b0};
            5'd2:  mi = '{akf_pkg::OP_MUL, V_DT,   V_ACC,  V_T0,   1'b0, 1'b0};
            5'd3:  mi = '{akf_pkg::OP_ADD, V_SPD,  V_T0,   V_PS,   1'b0, 1'b0};
            5'd4:  mi = '{akf_pkg::OP_MUL, V_DT,   V_PSS,  V_T0,   1'b0, 1'b0};
            5'd5:  mi = '{akf_pkg::OP_ADD, V_PSA,  V_T0,   V_P1SA, 1'b0, 1'b0};
            5'd6:  mi = '{akf_pkg::OP_ADD, V_PAS,  V_T0,   V_P1AS, 1'b0, 1'b0};
            5'd7:  mi = '{akf_pkg::OP_MUL, V_DT,   V_PAS,  V_T0,   1'b0, 1'b0};
            5'd8:  mi = '{akf_pkg::OP_ADD, V_PAA,  V_T0,   V_T0,   1'b0, 1'b0};
            5'd9:  mi = '{akf_pkg::OP_MUL, V_DT,   V_P1SA, V_T1,   1'b0, 1'b0};
            5'd10: mi = '{akf_pkg::OP_ADD, V_T0,   V_T1,   V_P1AA, 1'b0, 1'b0};
            5'd11: mi = '{akf_pkg::OP_MUL, V_DT,   V_DT,   V_T0,   1'b0, 1'b0};
            5'd12: mi = '{akf_pkg::OP_MUL, V_T0,   V_Q,    V_T0,   1'b0, 1'b0};
            5'd13: mi = '{akf_pkg::OP_ADD, V_PSS,  V_T0,   V_P1SS, 1'b0, 1'b0};
            5'd14: mi = '{akf_pkg::OP_ADD, V_P1AA, V_R,    V_S,    1'b0, 1'b0};
            5'd15: mi = '{akf_pkg::OP_ADD, V_P1AA, V_S,    V_KA,   1'b1, 1'b0};
            5'd16: mi = '{akf_pkg::OP_ADD, V_P1SA, V_S,    V_KS,   1'b1, 1'b0};
            5'd17: mi = '{akf_pkg::OP_SUB, V_MEAS, V_PA,   V_INNOV, 1'b0, 1'b0};
            5'd18: mi = '{akf_pkg::OP_MUL, V_KA,   V_INNOV, V_T0,  1'b0, 1'b0};
            5'd19: mi = '{akf_pkg::OP_ADD, V_PA,   V_T0,   V_ALT,  1'b0, 1'b0};
            5'd20: mi = '{akf_pkg::OP_MUL, V_KS,   V_INNOV, V_T0,  1'b0, 1'b0};
            5'd21: mi = '{akf_pkg::OP_ADD, V_PS,   V_T0,   V_SPD,  1'b0, 1'b0};
            5'd22: mi = '{akf_pkg::OP_SUB, V_ONE,  V_KA,   V_NKA,  1'b0, 1'b0};
            5'd23: mi = '{akf_pkg::OP_MUL, V_NKA,  V_P1AA, V_PAA,  1'b0, 1'b0};
            5'd24: mi = '{akf_pkg::OP_MUL, V_NKA,  V_P1AS, V_PAS,  1'b0, 1'b0};
            5'd25: mi = '{akf_pkg::OP_MUL, V_KS,   V_P1AA, V_T0,   1'b0, 1'b0};
            5'd26: mi = '{akf_pkg::OP_SUB, V_P1SA, V_T0,   V_PSA,  1'b0, 1'b0};
            5'd27: mi = '{akf_pkg::OP_MUL, V_KS,   V_P1AS, V_T0,   1'b0, 1'b0};
            5'd28: mi = '{akf_pkg::OP_SUB, V_P1SS, V_T0,   V_PSS,  1'b0, 1'b1};
            default: mi = '{akf_pkg::OP_ADD, V_ALT, V_ALT, V_T0, 1'b0, 1'b1};
        endcase
    end

    akf_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .clk(clk), .rst_n(rst_n), .start(alu_start), .op(mi.op),
        .a(slot_reg[mi.a]), .b(slot_reg[mi.b]),
        .done(alu_done), .result(alu_res), .clip(alu_clip)
    );

    akf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(slot_reg[mi.a]), .den(slot_reg[mi.b]),
        .done(div_done), .quot(div_res), .clip(div_clip)
    );

    // Sequencer: issue a step, wait for its unit, then move on.
    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        alu_start = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            akf_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = mi.div ? akf_pkg::ST_DIV_START : akf_pkg::ST_ALU;
                    step_next = '0;
                end
            end
            akf_pkg::ST_ALU:
            begin
                alu_start = 1'b1;
                state_next = akf_pkg::ST_DIV_WAIT;
            end
            akf_pkg::ST_DIV_START:
            begin
                div_start = 1'b1;
                state_next = akf_pkg::ST_DIV_WAIT;
            end
            akf_pkg::ST_DIV_WAIT:
            begin
                if (alu_done || div_done)
                begin
                    if (mi.last)
                        state_next = akf_pkg::ST_OUT;
                    else
                    begin
                        step_next = step_reg + 1'b1;
                        state_next = akf_pkg::ST_ALU;
                        if (step_reg == 5'd14 || step_reg == 5'd15)
                            state_next = akf_pkg::ST_DIV_START;
                    end
                end
            end
            akf_pkg::ST_OUT:
            begin
                if (m_axis_tready)
                    state_next = akf_pkg::ST_IDLE;
            end
            default: state_next = akf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= akf_pkg::ST_IDLE;
            step_reg <= '0;
            q_reg <= akf_pkg::PROCESS_NOISE_RESET;
            r_reg <= akf_pkg::MEAS_NOISE_RESET;
            avar_reg <= akf_pkg::ALT_VAR_RESET;
            svar_reg <= akf_pkg::SPEED_VAR_RESET;
            clip_reg <= 1'b0;
            slot_reg[V_ALT] <= '0;
            slot_reg[V_SPD] <= '0;
            slot_reg[V_PAA] <= $signed({1'b0, akf_pkg::ALT_VAR_RESET});
            slot_reg[V_PAS] <= '0;
            slot_reg[V_PSA] <= '0;
            slot_reg[V_PSS] <= $signed({1'b0, akf_pkg::SPEED_VAR_RESET});
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    akf_pkg::REG_PROCESS_NOISE: q_reg <= cfg_data;
                    akf_pkg::REG_MEAS_NOISE:    r_reg <= cfg_data;
                    akf_pkg::REG_ALT_VAR:
                    begin
                        avar_reg <= cfg_data;
                        slot_reg[V_PAA] <= $signed({1'b0, cfg_data});
                        slot_reg[V_PAS] <= '0;
                        slot_reg[V_PSA] <= '0;
                        slot_reg[V_PSS] <= $signed({1'b0, svar_reg});
                    end
                    akf_pkg::REG_SPEED_VAR:
                    begin
                        svar_reg <= cfg_data;
                        slot_reg[V_PAA] <= $signed({1'b0, avar_reg});
                        slot_reg[V_PAS] <= '0;
                        slot_reg[V_PSA] <= '0;
                        slot_reg[V_PSS] <= $signed({1'b0, cfg_data});
                    end
                    default: ;
                endcase
            end
            if (state_reg == akf_pkg::ST_IDLE && s_axis_tvalid)
            begin
                clip_reg <= 1'b0;
                slot_reg[V_MEAS] <= $signed(s_axis_tdata[31:0]);
                slot_reg[V_ACC] <= $signed(s_axis_tdata[63:32]);
                slot_reg[V_DT] <= $signed({15'd0, s_axis_tdata[80:64]});
                slot_reg[V_Q] <= $signed({1'b0, q_reg});
                slot_reg[V_R] <= $signed({1'b0, r_reg});
                slot_reg[V_ONE] <= 32'sd1 <<< FRAC_BITS;
            end
            else if (state_reg == akf_pkg::ST_DIV_WAIT && (alu_done || div_done))
            begin
                slot_reg[mi.d] <= div_done ? div_res : alu_res;
                clip_reg <= clip_reg | (div_done ? div_clip : alu_clip);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == akf_pkg::ST_DIV_WAIT && mi.last && alu_done)
            out_reg <= {7'd0, clip_reg | alu_clip, slot_reg[V_SPD], slot_reg[V_ALT]};
    end

    assign s_axis_tready = (state_reg == akf_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == akf_pkg::ST_OUT);
    assign m_axis_tdata = out_reg;

    // The two arithmetic units never report completion together.
    assert property (@(posedge clk) disable iff (!rst_n) !(alu_done && div_done))
        else $error("alu and divider finished together");
    // No new item is taken while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");
    // A result is only raised after the final step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(mi.last))
        else $error("result raised early");
endmodule
`default_nettype wire

/* hdl/akf_alu.sv */
`default_nettype none
// Shared add, subtract and rounded-multiply unit. One operation is
// registered per issue; a multiply is registered once more before rounding.
module akf_alu #(
    parameter int FRAC_BITS = akf_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire akf_pkg::alu_op_t              op,
    input  wire logic signed [31:0]            a,
    input  wire logic signed [31:0]            b,
    output logic                               done,
    output logic signed [31:0]                 result,
    output logic                               clip
);
    logic                  prod_valid_reg;
    logic signed [63:0]    prod_reg;
    logic                  done_reg;
    logic signed [31:0]    result_reg;
    logic                  clip_reg;
    logic signed [65:0]    sum;
    logic signed [65:0]    rounded;
    logic [32:0]           sat_sum;
    logic [32:0]           sat_mul;

    always_comb
    begin
        if (op == akf_pkg::OP_SUB)
            sum = 66'(a) - 66'(b);
        else
            sum = 66'(a) + 66'(b);
        // Adding half then an arithmetic shift floors, which equals the
        // rounding of the model for both signs.
        rounded = (66'(prod_reg) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        sat_sum = akf_pkg::sat32(sum);
        sat_mul = akf_pkg::sat32(rounded);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= start && (op == akf_pkg::OP_MUL);
            done_reg <= (start && (op != akf_pkg::OP_MUL)) || prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            prod_reg <= a * b;
        if (prod_valid_reg)
        begin
            result_reg <= sat_mul[31:0];
            clip_reg <= sat_mul[32];
        end
        else if (start)
        begin
            result_reg <= sat_sum[31:0];
            clip_reg <= sat_sum[32];
        end
    end

    assign done = done_reg;
    assign result = result_reg;
    assign clip = clip_reg;
endmodule
`default_nettype wire

/* hdl/akf_div.sv */
`default_nettype none
// Radix-2 restoring divider for the gain: (num << FRAC_BITS) / den,
// truncated toward zero and saturated. One quotient bit per cycle.
module akf_div #(
    parameter int FRAC_BITS = akf_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] num,
    input  wire logic signed [31:0] den,
    output logic                    done,
    output logic signed [31:0]      quot,
    output logic                    clip
);
    localparam int DW = 32 + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     count_reg;
    logic [DW-1:0]     dividend_reg;
    logic [31:0]       rem_reg;
    logic [31:0]       divisor_reg;
    logic              neg_reg;
    logic              zero_reg;
    logic [32:0]       rem_shift;
    logic [33:0]       trial;
    logic [DW:0]       q_signed;
    logic signed [65:0] q_ext;
    logic [32:0]       sat_q;
    logic [31:0]       num_abs;
    logic [31:0]       den_abs;

    always_comb
    begin
        num_abs = num[31] ? 32'(-num) : num;
        den_abs = den[31] ? 32'(-den) : den;
        rem_shift = {rem_reg, dividend_reg[DW-1]};
        trial = {1'b0, rem_shift} - {2'b00, divisor_reg};
        q_signed = neg_reg ? (DW+1)'(-{1'b0, dividend_reg}) : {1'b0, dividend_reg};
        q_ext = 66'($signed(q_signed));
        sat_q = akf_pkg::sat32(q_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= (den != 32'sd0);
                done_reg <= (den == 32'sd0);
                count_reg <= CW'(DW);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The partial remainder stays below the divisor, so 32 bits hold it.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dividend_reg <= {num_abs, {FRAC_BITS{1'b0}}};
            divisor_reg <= den_abs;
            rem_reg <= '0;
            neg_reg <= num[31] ^ den[31];
            zero_reg <= (den == 32'sd0);
        end
        else if (busy_reg)
        begin
            if (!trial[33])
            begin
                rem_reg <= trial[31:0];
                dividend_reg <= {dividend_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[31:0];
                dividend_reg <= {dividend_reg[DW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = zero_reg ? 32'sd0 : $signed(sat_q[31:0]);
    assign clip = zero_reg | sat_q[32];
endmodule
`default_nettype wire
